// File: rtl/circular_double_ended_queue_defines.svh
// Assertion macros used by the deque checker.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication
`define CDEQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cdeq_pkg.sv
// Types, codes and elaboration helpers of the double-ended queue.
package cdeq_pkg;

   localparam int WORD_W        = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 16;
   localparam int RADIX_LOG     = 4;
   localparam int RADIX         = 1 << RADIX_LOG;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic signed [WORD_W-1:0] NO_VALUE = -32'sd1;

   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic append_last;
      logic drop_last;
   } cell_op_type;

   // nodes left at a level of the rear-select tree
   function automatic int lvl_width(input int depth, input int level);
      int span;
      span = 1 << (RADIX_LOG * level);
      return (depth + span - 1) >> (RADIX_LOG * level);
   endfunction

   // registered levels needed to reduce depth leaves to one
   function automatic int sel_levels(input int depth);
      int levels;
      levels = 0;
      for (int i = 0; i < 8; i++) begin
         if ((1 << (RADIX_LOG * i)) < depth) levels = i + 1;
      end
      return levels;
   endfunction

endpackage

// File: rtl/cdeq_if.sv
// Valid/ready channels for deque commands and responses.
interface cdeq_req_if;
   logic                                valid;
   logic                                ready;
   logic [cdeq_pkg::CMD_W-1:0]          cmd;
   logic signed [cdeq_pkg::WORD_W-1:0]  push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdeq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cdeq_pkg::WORD_W-1:0]  pop_value;
   logic [cdeq_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output pop_value, output status, input ready);
   modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// File: rtl/cdeq_cell.sv
// One storage cell of the deque row; exchanges its word with both neighbors.
module cdeq_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  cdeq_pkg::cell_op_type               op,
   input  logic signed [cdeq_pkg::WORD_W-1:0]  push_value,
   input  logic signed [cdeq_pkg::WORD_W-1:0]  left_value,
   input  logic                                left_valid,
   input  logic signed [cdeq_pkg::WORD_W-1:0]  right_value,
   input  logic                                right_valid,
   output logic signed [cdeq_pkg::WORD_W-1:0]  value,
   output logic                                valid,
   output logic [cdeq_pkg::WORD_W-1:0]         sel_value
);

   logic signed [cdeq_pkg::WORD_W-1:0] value_ff, value_in;
   logic                               valid_ff, valid_in;
   logic                               last;

   assign last = valid_ff && !right_valid;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (op.shift_in) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (op.shift_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (op.append_last && !valid_ff && left_valid) begin
         value_in = push_value;
         valid_in = 1'b1;
      end else if (op.drop_last && last) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign valid     = valid_ff;
   assign sel_value = last ? value_ff : '0;

endmodule

// File: rtl/cdeq_sel.sv
// Registered OR tree that picks out the word of the rear cell.
module cdeq_sel #(
   parameter int DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   drain,
   input  logic [DEPTH-1:0][cdeq_pkg::WORD_W-1:0] leaf,
   output logic [cdeq_pkg::WORD_W-1:0]            result,
   output logic                                   done
);

   localparam int W      = cdeq_pkg::WORD_W;
   localparam int LEVELS = cdeq_pkg::sel_levels(DEPTH);

   logic [DEPTH-1:0][W-1:0] node [LEVELS+1];
   logic                    go   [LEVELS+1];

   assign node[0] = leaf;
   assign go[0]   = start;

   for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
      localparam int WK = cdeq_pkg::lvl_width(DEPTH, k);
      localparam int WP = cdeq_pkg::lvl_width(DEPTH, k - 1);

      logic [WK-1:0][W-1:0] lvl_ff, lvl_in;
      logic                 stage_ff, stage_in;

      always_comb begin
         lvl_in = lvl_ff;
         if (go[k-1]) begin
            lvl_in = '0;
            for (int j = 0; j < WK; j++) begin
               for (int r = 0; r < cdeq_pkg::RADIX; r++) begin
                  if (j * cdeq_pkg::RADIX + r < WP) begin
                     lvl_in[j] = lvl_in[j] | node[k-1][j * cdeq_pkg::RADIX + r];
                  end
               end
            end
         end
      end

      if (k == LEVELS) begin : g_last
         assign stage_in = go[k-1] || (stage_ff && !drain);
      end else begin : g_mid
         assign stage_in = go[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff <= 1'b0;
         end else begin
            stage_ff <= stage_in;
         end
      end

      always_ff @(posedge clock) begin
         lvl_ff <= lvl_in;
      end

      assign node[k] = {{((DEPTH - WK) * W){1'b0}}, lvl_ff};
      assign go[k]   = stage_ff;
   end

   assign result = node[LEVELS][0];
   assign done   = go[LEVELS];

endmodule

// File: rtl/circular_double_ended_queue.sv
// Top level of the double-ended queue built as a row of shifting cells.
// Usage: each command on req_bus (push front, push rear, pop front, pop rear) returns
// exactly one response on rsp_bus with the popped word (-1 on pushes and failed pops)
// and a status of ok, full or empty. The queue is kept front-aligned in a row of DEPTH
// cells: pushes and pops at the front shift the whole row by one cell, rear operations
// touch only the first empty or the last occupied cell. A response reaches the output
// register once its command has passed the LEVELS registered levels of the tree that
// fetches the rear word, LEVELS = ceil(log16(DEPTH)), i.e. 1 up to 16 entries, 2 up to
// 256, 3 up to 4096; the last level holds its result while the output is full.
// The next command is accepted in the cycle its predecessor's response is loaded, so
// commands never overlap in the tree. The output register holds one response while
// the next command is in flight. No clearing pass after reset.
module circular_double_ended_queue #(
   parameter int DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   cdeq_req_if.sink   req_bus,
   cdeq_rsp_if.source rsp_bus
);

   localparam int W = cdeq_pkg::WORD_W;

   logic signed [W-1:0]   cell_value [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0][W-1:0] cell_sel;

   cdeq_pkg::cell_op_type op;
   logic                  full, empty, accept, load;
   logic [W-1:0]          sel_result;
   logic                  sel_done;

   logic                             busy_ff, busy_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]              rsp_value_ff, rsp_value_in;
   logic [cdeq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic signed [W-1:0]              value_ff, value_in;
   logic [cdeq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                             use_tree_ff, use_tree_in;

   assign full  = cell_valid[DEPTH-1];
   assign empty = !cell_valid[0];

   assign load          = sel_done && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !busy_ff || load;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      op          = '0;
      value_in    = cdeq_pkg::NO_VALUE;
      status_in   = cdeq_pkg::STATUS_OK;
      use_tree_in = 1'b0;
      case (req_bus.cmd)
         cdeq_pkg::CMD_PUSH_FRONT: begin
            op.shift_in = accept && !full;
            if (full) status_in = cdeq_pkg::STATUS_FULL;
         end
         cdeq_pkg::CMD_PUSH_REAR: begin
            op.append_last = accept && !full;
            if (full) status_in = cdeq_pkg::STATUS_FULL;
         end
         cdeq_pkg::CMD_POP_FRONT: begin
            op.shift_out = accept && !empty;
            if (empty) status_in = cdeq_pkg::STATUS_EMPTY;
            else value_in = cell_value[0];
         end
         default: begin
            op.drop_last = accept && !empty;
            if (empty) status_in = cdeq_pkg::STATUS_EMPTY;
            else use_tree_in = 1'b1;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [W-1:0] left_value, right_value;
      logic                left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_value = req_bus.push_value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      cdeq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .push_value  (req_bus.push_value),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .sel_value   (cell_sel[i])
      );
   end

   cdeq_sel #(
      .DEPTH (DEPTH)
   ) u_sel (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .drain  (load),
      .leaf   (cell_sel),
      .result (sel_result),
      .done   (sel_done)
   );

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (load) busy_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;

      rsp_value_in  = use_tree_ff ? $signed(sel_result) : value_ff;
      rsp_status_in = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff    <= value_in;
         status_ff   <= status_in;
         use_tree_ff <= use_tree_in;
      end
      if (load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pop_value = rsp_value_ff;
   assign rsp_bus.status    = rsp_status_ff;

endmodule

// File: rtl/cdeq_checker.sv
// Port-level checker of the double-ended queue and its bind to the top level.
`include "circular_double_ended_queue_defines.svh"

module cdeq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [cdeq_pkg::CMD_W-1:0]          req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cdeq_pkg::WORD_W-1:0]  rsp_pop_value,
   input logic [cdeq_pkg::STATUS_W-1:0]       rsp_status
);

   logic       in_acc, out_acc, is_push;
   logic [1:0] count_ff, count_in, pos;
   logic [1:0] push_q_ff, push_q_in;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;
   assign is_push = (req_cmd == cdeq_pkg::CMD_PUSH_FRONT) ||
                    (req_cmd == cdeq_pkg::CMD_PUSH_REAR);
   assign pos     = count_ff - {1'b0, out_acc};

   always_comb begin
      count_in  = count_ff + {1'b0, in_acc} - {1'b0, out_acc};
      push_q_in = push_q_ff;
      if (out_acc) push_q_in = {1'b0, push_q_ff[1]};
      if (in_acc) push_q_in[pos[0]] = is_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         push_q_ff <= '0;
      end else begin
         count_ff  <= count_in;
         push_q_ff <= push_q_in;
      end
   end

   `CDEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pop_value) && $stable(rsp_status),
      "stalled response changed")
   `CDEQ_ASSERT_IMPLY(a_no_orphan, clock, reset, out_acc, count_ff != 2'd0,
      "response without a command")
   `CDEQ_ASSERT_IMPLY(a_bounded, clock, reset, in_acc && count_ff == 2'd2, out_acc,
      "more than two transactions outstanding")
   `CDEQ_ASSERT_IMPLY(a_push_rsp, clock, reset, rsp_valid && count_ff != 2'd0 && push_q_ff[0],
      rsp_pop_value == cdeq_pkg::NO_VALUE && rsp_status != cdeq_pkg::STATUS_EMPTY,
      "bad response to a push")

endmodule

bind circular_double_ended_queue cdeq_checker u_cdeq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_cmd       (req_bus.cmd),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pop_value (rsp_bus.pop_value),
   .rsp_status    (rsp_bus.status)
);
